// ===== rtl/core/iirdf2_pkg.sv =====
package iirdf2_pkg;

    localparam int TAPS        = 3;
    localparam int COEF_SLOTS  = 3;
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int DATA_W      = 32;
    localparam int ACC_W       = 64;
    localparam int SHIFT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIGIT_W     = 8;
    localparam int NUM_DIGITS  = COEF_W / DIGIT_W;
    localparam int CNT_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int K_W         = $clog2(TAPS);
    localparam int SLOT_W      = $clog2(COEF_SLOTS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0    = 3'd0,
        CFG_B1    = 3'd1,
        CFG_B2    = 3'd2,
        CFG_A1    = 3'd3,
        CFG_A2    = 3'd4,
        CFG_SHIFT = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FB_GO,
        S_FB_WAIT,
        S_W0,
        S_FF_GO,
        S_FF_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [COEF_SLOTS-1:0][COEF_W-1:0] coef_b;
        logic [COEF_SLOTS-1:0][COEF_W-1:0] coef_a;
        logic [SHIFT_W-1:0]                frac_shift;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{coef_b: '0, coef_a: '0, frac_shift: 4'd15};

    typedef struct packed {
        logic              init;
        logic [ACC_W-1:0]  init_val;
        logic              start;
        logic              sub;
        logic [COEF_W-1:0] coef;
        logic [DATA_W-1:0] mult;
    } t_mac_cmd;

endpackage

// ===== rtl/core/iirdf2_cfg.sv =====
module iirdf2_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iirdf2_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output iirdf2_pkg::t_cfg                    o_cfg
);
    import iirdf2_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_B0:    r_cfg.coef_b[0]  <= i_cfg_data[COEF_W-1:0];
                CFG_B1:    r_cfg.coef_b[1]  <= i_cfg_data[COEF_W-1:0];
                CFG_B2:    r_cfg.coef_b[2]  <= i_cfg_data[COEF_W-1:0];
                CFG_A1:    r_cfg.coef_a[1]  <= i_cfg_data[COEF_W-1:0];
                CFG_A2:    r_cfg.coef_a[2]  <= i_cfg_data[COEF_W-1:0];
                CFG_SHIFT: r_cfg.frac_shift <= i_cfg_data[SHIFT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/iirdf2_mac.sv =====
module iirdf2_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  iirdf2_pkg::t_mac_cmd            i_cmd,
    output logic                            o_last,
    output logic [iirdf2_pkg::ACC_W-1:0]    o_acc
);
    import iirdf2_pkg::*;

    logic                      r_busy;
    logic [CNT_W-1:0]          r_cnt;
    logic [COEF_W-1:0]         r_coef_sr;
    logic signed [DATA_W-1:0]  r_mult;
    logic                      r_sub;
    logic [ACC_W-1:0]          r_acc;

    logic                          last;
    logic signed [DIGIT_W:0]       dig;
    logic signed [DATA_W+DIGIT_W:0] prod;
    logic [ACC_W-1:0]              term;

    always_comb begin
        last = r_busy && (r_cnt == CNT_W'(NUM_DIGITS - 1));
        if (r_cnt == CNT_W'(NUM_DIGITS - 1)) begin
            dig = {r_coef_sr[DIGIT_W-1], r_coef_sr[DIGIT_W-1:0]};
        end else begin
            dig = {1'b0, r_coef_sr[DIGIT_W-1:0]};
        end
        prod = r_mult * dig;
        term = ACC_W'(prod) << (r_cnt * DIGIT_W);
    end

    assign o_last = last;
    assign o_acc  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_coef_sr <= i_cmd.coef;
            r_mult    <= i_cmd.mult;
            r_sub     <= i_cmd.sub;
        end else if (r_busy) begin
            r_coef_sr <= r_coef_sr >> DIGIT_W;
        end
        if (i_cmd.init) begin
            r_acc <= i_cmd.init_val;
        end else if (r_busy) begin
            r_acc <= r_sub ? (r_acc - term) : (r_acc + term);
        end
    end

endmodule

// ===== rtl/core/iir_direct_form2_fixed_point.sv =====
// Second-order IIR filter, direct form II, fixed point with 64-bit accumulation.
// Input channel: i_in_valid / o_in_stall with i_sample_in (16-bit signed).
// A sample is taken at an edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with o_sample_out (32-bit signed);
// a result is taken at an edge with o_out_valid high and i_out_stall low.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0..4 = b0, b1, b2, a1, a2, index 5 = frac_shift, higher indexes dropped.
// One shared MAC forms each 16x32 product one 8-bit coefficient digit per
// cycle, as an issue step plus 2 digit steps. A sample takes 2*TAPS-1
// products: feedback a2, a1, then the w0 update, then feedforward b2, b1,
// b0; the result is then loaded and the next request is taken after it.
// The output register holds a result while the next sample is computed; a
// stalled receiver only holds the block once a second result is ready.
// Reset clears the delay line, coefficients to zero and frac_shift to 15.
module iir_direct_form2_fixed_point (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [iirdf2_pkg::SAMPLE_W-1:0]  i_sample_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [iirdf2_pkg::DATA_W-1:0]    o_sample_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [iirdf2_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import iirdf2_pkg::*;

    t_cfg                   cfg;
    t_mac_cmd               mac_cmd;
    logic                   mac_last;
    logic [ACC_W-1:0]       mac_acc;

    t_state                 r_state;
    t_state                 n_state;
    logic [K_W-1:0]         r_k;
    logic [TAPS-1:0][DATA_W-1:0] r_w;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_data;

    logic                   k_set;
    logic                   k_dec;
    logic                   w0_load;
    logic                   out_load;
    logic [ACC_W-1:0]       acc_shr;
    logic [ACC_W-1:0]       in_scaled;

    iirdf2_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    iirdf2_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (mac_cmd),
        .o_last  (mac_last),
        .o_acc   (mac_acc)
    );

    assign acc_shr   = mac_acc >> cfg.frac_shift;
    assign in_scaled = ACC_W'(i_sample_in) << cfg.frac_shift;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_FB_GO;
                end
            end
            S_FB_GO:   n_state = S_FB_WAIT;
            S_FB_WAIT: begin
                if (mac_last) begin
                    n_state = (r_k == K_W'(1)) ? S_W0 : S_FB_GO;
                end
            end
            S_W0:      n_state = S_FF_GO;
            S_FF_GO:   n_state = S_FF_WAIT;
            S_FF_WAIT: begin
                if (mac_last) begin
                    n_state = (r_k == '0) ? S_OUT : S_FF_GO;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mac_cmd  = '0;
        k_set    = 1'b0;
        k_dec    = 1'b0;
        w0_load  = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mac_cmd.init     = i_in_valid;
                mac_cmd.init_val = in_scaled;
                k_set            = i_in_valid;
            end
            S_FB_GO: begin
                mac_cmd.start = 1'b1;
                mac_cmd.sub   = 1'b1;
                mac_cmd.coef  = cfg.coef_a[SLOT_W'(r_k)];
                mac_cmd.mult  = r_w[r_k];
            end
            S_FB_WAIT: begin
                k_dec = mac_last && (r_k != K_W'(1));
            end
            S_W0: begin
                w0_load          = 1'b1;
                mac_cmd.init     = 1'b1;
                mac_cmd.init_val = '0;
                k_set            = 1'b1;
            end
            S_FF_GO: begin
                mac_cmd.start = 1'b1;
                mac_cmd.sub   = 1'b0;
                mac_cmd.coef  = cfg.coef_b[SLOT_W'(r_k)];
                mac_cmd.mult  = r_w[r_k];
            end
            S_FF_WAIT: begin
                k_dec = mac_last && (r_k != '0);
            end
            S_OUT: begin
                out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_w         <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w0_load) begin
                r_w[0] <= acc_shr[DATA_W-1:0];
            end
            if (out_load) begin
                for (int i = TAPS - 1; i >= 1; i--) begin
                    r_w[i] <= r_w[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (k_set) begin
            r_k <= K_W'(TAPS - 1);
        end else if (k_dec) begin
            r_k <= r_k - K_W'(1);
        end
        if (out_load) begin
            r_out_data <= acc_shr[DATA_W-1:0];
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

    a_last_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_last |-> (r_state == S_FB_WAIT || r_state == S_FF_WAIT))
        else $error("MAC finished outside a wait state");

    a_fb_not_w0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FB_GO) |-> (r_k != '0))
        else $error("feedback product issued on w0");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not raise valid");

endmodule

// ===== tb/iir_direct_form2_fixed_point_test.sv =====
module iir_direct_form2_fixed_point_test;

    import iirdf2_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample_in = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [DATA_W-1:0]    o_sample_out;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    iir_direct_form2_fixed_point dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter shadow state
    logic signed [COEF_W-1:0] coef_b [COEF_SLOTS];
    logic signed [COEF_W-1:0] coef_a [COEF_SLOTS];
    logic [SHIFT_W-1:0]       shift_q;
    logic signed [DATA_W-1:0] delay_w [TAPS];

    logic signed [SAMPLE_W-1:0] sample_q [$];
    logic signed [DATA_W-1:0]   expected_out [$];

    int queued_cnt = 0;
    int in_cnt = 0;
    int out_cnt = 0;
    int cfg_cnt = 0;
    int settings_cnt = 0;
    int err_cnt = 0;
    int idle_cycles = 0;
    bit in_taken = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int hold_at = 400;
    int stall_mode = 0;
    int mode_left = 0;

    function automatic logic signed [DATA_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x
    );
        longint acc;
        logic signed [DATA_W-1:0] w0;
        acc = longint'(x) <<< shift_q;
        acc -= longint'(coef_a[1]) * longint'(delay_w[1]);
        acc -= longint'(coef_a[2]) * longint'(delay_w[2]);
        w0 = DATA_W'(acc >>> shift_q);
        acc = longint'(coef_b[0]) * longint'(w0)
            + longint'(coef_b[1]) * longint'(delay_w[1])
            + longint'(coef_b[2]) * longint'(delay_w[2]);
        delay_w[2] = delay_w[1];
        delay_w[1] = w0;
        delay_w[0] = w0;
        return DATA_W'(acc >>> shift_q);
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_B0: coef_b[0] = data;
            CFG_B1: coef_b[1] = data;
            CFG_B2: coef_b[2] = data;
            CFG_A1: coef_a[1] = data;
            CFG_A2: coef_a[2] = data;
            CFG_SHIFT: shift_q = data[SHIFT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($signed($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cfg(idx, data);
        cfg_cnt++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] vals [6],
                                 input logic [5:0] mask);
        t_cfg_idx regs [6];
        regs = '{CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2, CFG_SHIFT};
        for (int r = 0; r < 6; r++)
            if (mask[r]) write_reg(regs[r], vals[r]);
        settings_cnt++;
    endtask

    task automatic feed(input logic signed [SAMPLE_W-1:0] s);
        sample_q.push_back(s);
        queued_cnt++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (in_cnt != queued_cnt || expected_out.size() != 0) @(negedge i_clk);
    endtask

    // sender: bursts of requests with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0 || sample_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                i_in_valid  <= 1'b1;
                i_sample_in <= sample_q.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // receiver: long hold-offs for back pressure, else a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (in_cnt >= hold_at) begin
            i_out_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            hold_at += 600;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 150);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // check results, predict accepted requests, watch for a hang
    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] want;
        bit moved;
        moved = 1'b0;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                out_cnt++;
                if (expected_out.size() == 0) begin
                    $error("sample_out unexpected: got %0d with nothing pending", o_sample_out);
                    err_cnt++;
                end else begin
                    want = expected_out.pop_front();
                    if (o_sample_out !== want) begin
                        $error("sample_out mismatch: expected %0d, got %0d",
                               want, o_sample_out);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                in_taken = 1'b1;
                in_cnt++;
                expected_out.push_back(filter_sample(i_sample_in));
            end
            if (i_cfg_valid && o_cfg_ready) moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles with no transfer", IDLE_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] vals [6];
        logic [SHIFT_W-1:0] shift_pick;
        for (int k = 0; k < COEF_SLOTS; k++) begin
            coef_b[k] = '0;
            coef_a[k] = '0;
        end
        for (int k = 0; k < TAPS; k++) delay_w[k] = '0;
        shift_q = CFG_RESET.frac_shift;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset coefficients
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sh0001);
        drain();

        // most negative coefficients, full shift, spare indexes ignored
        vals = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF};
        load_settings(vals, 6'h3F);
        write_reg(CFG_SPARE_LO, 16'h0003);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(-16'sd1);
        feed(16'sh0000);
        feed(16'sh7FFF);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sh0001);
        drain();

        // most positive coefficients, no shift
        vals = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFF0};
        load_settings(vals, 6'h3F);
        feed(16'sh8000);
        feed(16'sh7FFF);
        feed(16'sh0000);
        feed(-16'sd1);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sd5);
        drain();

        // a high-pass section in Q14
        vals = '{16'h4000, 16'h8000, 16'h4000, 16'h8CCD, 16'h3333, 16'h000E};
        load_settings(vals, 6'h3F);
        feed(16'sh7FFF);
        feed(16'sh7FFF);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sh8000);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: shift_pick = '0;
                1: shift_pick = '1;
                default: shift_pick = SHIFT_W'($urandom);
            endcase
            for (int r = 0; r < 5; r++) vals[r] = pick_coef();
            vals[5] = {12'($urandom), shift_pick};
            load_settings(vals, (p < 2) ? 6'h3F : 6'($urandom));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                          16'($urandom));
            repeat (PHASE_ITEMS) feed(rand_sample());
            drain();
        end

        repeat (40) @(negedge i_clk);
        $display("filtered %0d samples over %0d coefficient sets, %0d register writes",
                 in_cnt, settings_cnt, cfg_cnt);
        $display("compared %0d outputs, %0d mismatches", out_cnt, err_cnt);
        if (expected_out.size() != 0) begin
            $error("sample_out missing: %0d results never arrived", expected_out.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
